FILE: rtl/mcww_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the Markov chain word walker.
// No dependencies; every rtl file imports this package.
package mcww_pkg;

    localparam int WORD_W  = 12;
    localparam int SLOT_W  = 5;
    localparam int CNT_W   = 5;
    localparam int SUCC_AW = WORD_W + SLOT_W;
    localparam int DVD_W   = 32;
    localparam int DIV_W   = 13;

    localparam logic [CNT_W-1:0] MAX_SUCC  = 5'd30;
    localparam logic [DIV_W-1:0] WORDS_MAX = 13'd4096;

    // Reciprocals: floor(2^41 / 900) and ceil(2^45 / 810000)
    localparam logic [31:0] M900  = 32'd2443359172;
    localparam logic [25:0] M810K = 26'd43437497;
    localparam logic [10:0] DRAW_RANGE = 11'd900;

    // action codes
    localparam logic [2:0] A_LOAD_SUCC = 3'd0;
    localparam logic [2:0] A_LOAD_HDR  = 3'd1;
    localparam logic [2:0] A_SEED      = 3'd2;
    localparam logic [2:0] A_STEP      = 3'd3;
    localparam logic [2:0] A_PICK      = 3'd4;

    // emit kinds
    localparam logic [2:0] K_NONE   = 3'd0;
    localparam logic [2:0] K_WORD   = 3'd1;
    localparam logic [2:0] K_CAP    = 3'd2;
    localparam logic [2:0] K_PERIOD = 3'd3;
    localparam logic [2:0] K_PICK   = 3'd4;

    // config register indexes
    localparam logic [0:0] CFG_START = 1'd0;
    localparam logic [0:0] CFG_COUNT = 1'd1;

    typedef struct packed {
        logic [2:0]        action;
        logic [WORD_W-1:0] entry_index;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] successor;
        logic [CNT_W-1:0]  child_count;
        logic              end_mark;
        logic [31:0]       seed_value;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] word_index;
        logic [2:0]        emit_kind;
        logic              substitute_word;
        logic              error;
    } t_out_item;

    typedef struct packed {
        logic             end_mark;
        logic [CNT_W-1:0] count;
    } t_hdr;

    typedef struct packed {
        logic               succ_we;
        logic [SUCC_AW-1:0] succ_waddr;
        logic [WORD_W-1:0]  succ_wdata;
        logic               succ_re;
        logic [SUCC_AW-1:0] succ_raddr;
        logic               hdr_we;
        logic [WORD_W-1:0]  hdr_waddr;
        t_hdr               hdr_wdata;
        logic               hdr_re;
        logic [WORD_W-1:0]  hdr_raddr;
    } t_tbl_req;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] remainder;
    } t_div_rsp;

    function automatic logic [31:0] xorshift32(input logic [31:0] s);
        logic [31:0] x;
        x = s ^ (s << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage

FILE: rtl/mcww_tables.sv
`timescale 1ns / 1ps
// Successor table and word header memories, with registered reads.
// Depends on mcww_pkg.
module mcww_tables import mcww_pkg::*; (
    input  logic              i_clk,
    input  t_tbl_req          i_req,
    output logic [WORD_W-1:0] o_succ,
    output t_hdr              o_hdr
);

    // successor entries addressed {word, slot}
    logic [WORD_W-1:0] r_succ_mem [0:(2**SUCC_AW)-1];
    t_hdr              r_hdr_mem  [0:(2**WORD_W)-1];
    logic [WORD_W-1:0] r_succ_rd;
    t_hdr              r_hdr_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.succ_we) begin
            r_succ_mem[i_req.succ_waddr] <= i_req.succ_wdata;
        end
        if (i_req.succ_re) begin
            r_succ_rd <= r_succ_mem[i_req.succ_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.hdr_we) begin
            r_hdr_mem[i_req.hdr_waddr] <= i_req.hdr_wdata;
        end
        if (i_req.hdr_re) begin
            r_hdr_rd <= r_hdr_mem[i_req.hdr_raddr];
        end
    end

    assign o_succ = r_succ_rd;
    assign o_hdr  = r_hdr_rd;

endmodule

FILE: rtl/mcww_divider.sv
`timescale 1ns / 1ps
// Bit-serial restoring remainder, one dividend bit per cycle.
// Depends on mcww_pkg.
module mcww_divider import mcww_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [4:0]       r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DIV_W-1:0] r_div;
    logic [DIV_W-1:0] r_rem;

    logic [DIV_W:0]   shifted;
    logic [DIV_W-1:0] n_rem;

    always_comb begin
        shifted = {r_rem, r_dvd[DVD_W-1]};
        if (shifted >= {1'b0, r_div}) begin
            n_rem = DIV_W'(shifted - {1'b0, r_div});
        end else begin
            n_rem = shifted[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem[WORD_W-1:0];

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.start && r_busy))
        else $error("divider started while running");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_div != '0) |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");

    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("done without a finished run");
`endif

endmodule

FILE: rtl/markov_chain_word_walker_top.sv
`timescale 1ns / 1ps
// Top level of the Markov chain word walker: control sequencer and draw datapath.
// Depends on mcww_pkg, mcww_tables, mcww_divider.
//
// Usage
//   Input channel: an item is taken at a rising edge with i_start high and
//   o_busy low. Each item gives exactly one result on o_result, marked by
//   o_done for a single cycle; the receiver cannot stall, so take it then.
//   Config: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0 start word, 1 word total); write only while the block is idle.
//   Loads, seed and unused actions: result in the next cycle, and o_busy
//   stays low, so one such item per cycle.
//   Step: states S_MUL to S_FIN run the chain of three dependent table reads
//   (word header, then successor, then the successor's header) around the
//   mod-900 reduction and slot scaling multipliers. A step from a word with
//   no successors returns an error.
//   Pick: the bit-serial remainder unit reduces the generator output modulo
//   the word total, capped at 4096.
//   Items run one at a time, so table accesses never overlap and need no
//   forwarding.
//   Reset: generator = 1, current word = 0, capitalize flag set,
//   start word = 0, word total = 4096. Table contents are undefined until
//   loaded; there is no clearing pass.
module markov_chain_word_walker_top import mcww_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_in_item             i_item,
    output logic                 o_busy,
    output logic                 o_done,
    output t_out_item            o_result,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [DIV_W-1:0]     i_cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_RED   = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_SCALE = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_SUCC  = 4'd6;
    localparam logic [3:0] S_NXT   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_PICK  = 4'd9;

    // control state
    logic [3:0]        r_state, n_state;
    logic              r_done, n_done;
    logic [31:0]       r_rng, n_rng;
    logic [WORD_W-1:0] r_cur, n_cur;
    logic              r_cap, n_cap;
    logic [WORD_W-1:0] r_start;
    logic [DIV_W-1:0]  r_wcount;

    // payload / datapath
    t_out_item         r_result, n_result;
    logic [31:0]       r_x;
    logic [63:0]       r_prod;
    logic [10:0]       r_t;
    logic [19:0]       r_sq;
    logic [24:0]       r_p;
    logic [CNT_W-1:0]  r_n;
    logic [SLOT_W-1:0] r_sel;
    logic [DIV_W-1:0]  r_m;

    logic [31:0]       x_new;
    logic [DIV_W-1:0]  m_sat;
    logic [9:0]        r_draw;
    logic [50:0]       prod2;
    logic [5:0]        q6;
    logic [SLOT_W-1:0] sel;
    logic [WORD_W-1:0] pick_word;

    t_tbl_req          tbl_req;
    logic [WORD_W-1:0] tbl_succ;
    t_hdr              tbl_hdr;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    mcww_tables u_tables (
        .i_clk  (i_clk),
        .i_req  (tbl_req),
        .o_succ (tbl_succ),
        .o_hdr  (tbl_hdr)
    );

    mcww_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // datapath helpers
    always_comb begin
        x_new  = xorshift32(r_rng);
        m_sat  = (r_wcount > WORDS_MAX) ? WORDS_MAX : r_wcount;
        // final correction of x mod 900: estimate is low by at most one
        r_draw = (r_t >= DRAW_RANGE) ? 10'(r_t - DRAW_RANGE) : r_t[9:0];
        prod2  = 51'(r_p) * 51'(M810K);
        q6     = prod2[50:45];
        sel    = (q6 >= {1'b0, r_n}) ? SLOT_W'(r_n - 5'd1) : q6[SLOT_W-1:0];
        pick_word = (r_m == '0) ? '0 : div_rsp.remainder;
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_rng    = r_rng;
        n_cur    = r_cur;
        n_cap    = r_cap;
        n_result = r_result;

        tbl_req            = '0;
        tbl_req.succ_waddr = {i_item.entry_index, i_item.slot};
        tbl_req.succ_wdata = i_item.successor;
        tbl_req.succ_raddr = {r_cur, r_sel};
        tbl_req.hdr_waddr  = i_item.entry_index;
        tbl_req.hdr_wdata.end_mark = i_item.end_mark;
        tbl_req.hdr_wdata.count    = (i_item.child_count > MAX_SUCC) ?
                                     MAX_SUCC : i_item.child_count;
        tbl_req.hdr_raddr  = r_cur;

        div_req.start    = 1'b0;
        div_req.dividend = x_new;
        div_req.divisor  = m_sat;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_result = '0;
                    unique case (i_item.action)
                        A_LOAD_SUCC: begin
                            tbl_req.succ_we = (i_item.slot < MAX_SUCC);
                            n_done = 1'b1;
                        end
                        A_LOAD_HDR: begin
                            tbl_req.hdr_we = 1'b1;
                            n_done = 1'b1;
                        end
                        A_SEED: begin
                            n_rng  = i_item.seed_value;
                            n_cur  = r_start;
                            n_cap  = 1'b1;
                            n_done = 1'b1;
                        end
                        A_STEP: begin
                            tbl_req.hdr_re = 1'b1;
                            n_state = S_MUL;
                        end
                        A_PICK: begin
                            n_rng = x_new;
                            div_req.start = 1'b1;
                            n_state = S_PICK;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_MUL: begin
                if (tbl_hdr.count == '0) begin
                    // dead end: report, leave generator and word alone
                    n_result.error      = 1'b1;
                    n_result.word_index = r_cur;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RED;
                end
            end
            S_RED:   n_state = S_SQ;
            S_SQ:    n_state = S_SCALE;
            S_SCALE: n_state = S_DIV;
            S_DIV:   n_state = S_SUCC;
            S_SUCC: begin
                tbl_req.succ_re = 1'b1;
                n_state = S_NXT;
            end
            S_NXT: begin
                tbl_req.hdr_re    = 1'b1;
                tbl_req.hdr_raddr = tbl_succ;
                n_state = S_FIN;
            end
            S_FIN: begin
                n_result.word_index = tbl_succ;
                if (tbl_hdr.end_mark) begin
                    if (!r_cap) begin
                        n_result.emit_kind = K_PERIOD;
                        n_cap = 1'b1;
                    end else begin
                        n_result.emit_kind = K_NONE;
                    end
                end else begin
                    n_result.emit_kind = r_cap ? K_CAP : K_WORD;
                    n_cap = 1'b0;
                end
                n_rng   = r_x;
                n_cur   = tbl_succ;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_PICK: begin
                if (div_rsp.done) begin
                    n_result.word_index      = pick_word;
                    n_result.emit_kind       = K_PICK;
                    n_result.substitute_word = (pick_word == r_start);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_rng    <= 32'd1;
            r_cur    <= '0;
            r_cap    <= 1'b1;
            r_start  <= '0;
            r_wcount <= WORDS_MAX;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_rng   <= n_rng;
            r_cur   <= n_cur;
            r_cap   <= n_cap;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_START: r_start  <= i_cfg_data[WORD_W-1:0];
                    CFG_COUNT: r_wcount <= i_cfg_data;
                endcase
            end
        end
    end

    // draw pipeline: x mod 900, squared, scaled by child count, / 810000
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (r_state == S_IDLE) begin
            r_x <= x_new;
            r_m <= m_sat;
        end
        if (r_state == S_MUL) begin
            r_n    <= tbl_hdr.count;
            r_prod <= 64'(r_x) * 64'(M900);
        end
        if (r_state == S_RED) begin
            r_t <= 11'(r_x - 32'(32'(r_prod[63:41]) * 32'(DRAW_RANGE)));
        end
        if (r_state == S_SQ) begin
            r_sq <= 20'(r_draw) * 20'(r_draw);
        end
        if (r_state == S_SCALE) begin
            r_p <= 25'(r_sq) * 25'(r_n);
        end
        if (r_state == S_DIV) begin
            r_sel <= sel;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_fin_strobes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> o_done)
        else $error("step finished without a result strobe");

    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.error) |-> (o_result.emit_kind == K_NONE && $stable(r_rng)))
        else $error("dead-end step emitted or moved the generator");

    a_subst_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.substitute_word) |-> (o_result.emit_kind == K_PICK))
        else $error("start word flag outside a pick");

    a_pick_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.emit_kind == K_PICK) |-> !o_result.error)
        else $error("pick flagged an error");
`endif

endmodule
